[sv/tzbj_pkg.sv]
// Shared types and constants for the touch zone button and joystick decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tzbj_pkg;

   // Coordinate and arithmetic widths.
   localparam int COORD_W   = 12;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST_W    = SQ_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int BTN_W     = 3;
   localparam int BEV_W     = BTN_W + 1;

   // Virtual buttons sit on the diagonal at consecutive points.
   localparam int NUM_BUTTONS = 5;
   localparam logic [COORD_W-1:0] BTN_FIRST_POINT = 12'd10;
   localparam logic [COORD_W-1:0] BTN_LAST_POINT  =
      BTN_FIRST_POINT + COORD_W'(NUM_BUTTONS - 1);

   // Button mode: zero means no button held, otherwise button index plus one.
   localparam logic [BTN_W-1:0] MODE_NONE = 3'd0;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd2;

   // Event kinds on the result channel.
   localparam logic KIND_BUTTON = 1'b0;
   localparam logic KIND_STICK  = 1'b1;

   // Descriptor queue between the classifier and the event sequencer.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // Events one touch sample causes, in the order they are sent.
   typedef struct packed {
      logic               rel_vld;
      logic [BTN_W-1:0]   rel_btn;
      logic               prs_vld;
      logic [BTN_W-1:0]   prs_btn;
      logic               stk_vld;
      logic               stk_touched;
      logic [COORD_W-1:0] stk_x;
      logic [COORD_W-1:0] stk_y;
   } tzbj_desc_type;

   // A descriptor with its valid flag, as pushed into or read from the queue.
   typedef struct packed {
      logic          vld;
      tzbj_desc_type desc;
   } tzbj_entry_type;

endpackage

`default_nettype wire

[sv/tzbj_if.sv]
// Channel interfaces for touch samples and decoded events.
// Depends on tzbj_pkg for field widths.
`default_nettype none

// Touch sample channel.
interface tzbj_req_if import tzbj_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] touch_x;
   logic [COORD_W-1:0] touch_y;

   modport source (output valid, touch_x, touch_y, input ready);
   modport sink   (input valid, touch_x, touch_y, output ready);
endinterface

// Decoded event channel.
interface tzbj_rsp_if import tzbj_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               event_kind;
   logic [BEV_W-1:0]   button_event;
   logic [COORD_W-1:0] stick_x;
   logic [COORD_W-1:0] stick_y;
   logic               stick_touched;
   logic               last_of_run;

   modport source (output valid, event_kind, button_event, stick_x, stick_y,
                   stick_touched, last_of_run, input ready);
   modport sink   (input valid, event_kind, button_event, stick_x, stick_y,
                   stick_touched, last_of_run, output ready);
endinterface

`default_nettype wire

[sv/touch_zone_button_and_joystick.sv]
// Touch zone decoder: turns touch samples into virtual button and joystick
// events. Top level; depends on tzbj_pkg, the channel interfaces, tzbj_front,
// tzbj_queue and tzbj_back.
//
// Each touch sample gives zero to three event words: a release of the held
// button, a press of a button, and a joystick position or joystick release, in
// that order, with last_of_run set on the final word of the sample. A sample
// passes a two stage distance pipeline and is classified into a four entry
// queue; the event sequencer then sends one word per cycle while the result
// channel is ready; a sample without events leaves the queue with no word.
// Samples are accepted once per cycle while the queue has room for all
// samples in flight; the sustained rate is set by the event sequencer, one
// word per cycle while the result channel is ready. Configuration is written
// through the csr port while the block is idle; the user must keep to this,
// as the block does not enforce it. The radius is squared as it is written.
`default_nettype none

module touch_zone_button_and_joystick import tzbj_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tzbj_req_if.sink             req_chan,
   tzbj_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   tzbj_entry_type    push;
   tzbj_entry_type    head;
   logic              pop;
   logic [QCNT_W-1:0] q_count;

   tzbj_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .push      (push)
   );

   tzbj_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   tzbj_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/tzbj_front.sv]
// Front end: configuration registers, distance pipeline and event classifier.
// Depends on tzbj_pkg and tzbj_req_if; pushes descriptors into tzbj_queue.
`default_nettype none

module tzbj_front import tzbj_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tzbj_req_if.sink             req_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   input  logic [QCNT_W-1:0]    q_count,
   output tzbj_entry_type       push
);

   // Configuration; the radius is kept squared since only that is compared.
   logic [COORD_W-1:0] center_x_ff;
   logic [COORD_W-1:0] center_y_ff;
   logic [SQ_W-1:0]    radius_sq_ff;

   // Stage one: absolute distances and button point match.
   logic               s1_vld_ff;
   logic [COORD_W-1:0] s1_x_ff;
   logic [COORD_W-1:0] s1_y_ff;
   logic [COORD_W-1:0] s1_dx_ff;
   logic [COORD_W-1:0] s1_dy_ff;
   logic               s1_on_ff;
   logic [BTN_W-1:0]   s1_btn_ff;

   // Stage two: squared distances.
   logic               s2_vld_ff;
   logic [COORD_W-1:0] s2_x_ff;
   logic [COORD_W-1:0] s2_y_ff;
   logic [SQ_W-1:0]    s2_sqx_ff;
   logic [SQ_W-1:0]    s2_sqy_ff;
   logic               s2_on_ff;
   logic [BTN_W-1:0]   s2_btn_ff;

   // Decoder state.
   logic [BTN_W-1:0]   mode_ff;
   logic [BTN_W-1:0]   mode_in;
   logic               active_ff;
   logic               active_in;
   logic [COORD_W-1:0] last_x_ff;
   logic [COORD_W-1:0] last_x_in;
   logic [COORD_W-1:0] last_y_ff;
   logic [COORD_W-1:0] last_y_in;

   logic               accept;
   logic [QCNT_W:0]    occupancy;
   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic               on_point;
   logic [DIST_W-1:0]  dist_sq;
   logic               in_circle;
   logic [BTN_W-1:0]   held_btn;
   tzbj_desc_type      desc;

   // Accept only while the queue has room for every sample already in flight.
   assign occupancy = {1'b0, q_count} + (QCNT_W + 1)'(s1_vld_ff)
                    + (QCNT_W + 1)'(s2_vld_ff);
   assign req_chan.ready = occupancy < (QCNT_W + 1)'(QDEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   // Configuration writes; an unused index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         radius_sq_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_CENTER_X) begin
            center_x_ff <= csr_wdata;
         end
         if (csr_index == CSR_CENTER_Y) begin
            center_y_ff <= csr_wdata;
         end
         if (csr_index == CSR_RADIUS) begin
            radius_sq_ff <= SQ_W'(csr_wdata) * SQ_W'(csr_wdata);
         end
      end
   end

   // Stage one logic.
   assign dx = (req_chan.touch_x >= center_x_ff) ? req_chan.touch_x - center_x_ff
                                                 : center_x_ff - req_chan.touch_x;
   assign dy = (req_chan.touch_y >= center_y_ff) ? req_chan.touch_y - center_y_ff
                                                 : center_y_ff - req_chan.touch_y;
   assign on_point = (req_chan.touch_x == req_chan.touch_y)
                  && (req_chan.touch_x >= BTN_FIRST_POINT)
                  && (req_chan.touch_x <= BTN_LAST_POINT);

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      s1_x_ff   <= req_chan.touch_x;
      s1_y_ff   <= req_chan.touch_y;
      s1_dx_ff  <= dx;
      s1_dy_ff  <= dy;
      s1_on_ff  <= on_point;
      s1_btn_ff <= BTN_W'(req_chan.touch_x - BTN_FIRST_POINT);
      s2_x_ff   <= s1_x_ff;
      s2_y_ff   <= s1_y_ff;
      s2_sqx_ff <= SQ_W'(s1_dx_ff) * SQ_W'(s1_dx_ff);
      s2_sqy_ff <= SQ_W'(s1_dy_ff) * SQ_W'(s1_dy_ff);
      s2_on_ff  <= s1_on_ff;
      s2_btn_ff <= s1_btn_ff;
   end

   // Circle test.
   assign dist_sq   = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
   assign in_circle = dist_sq <= {1'b0, radius_sq_ff};
   assign held_btn  = mode_ff - 3'd1;

   // Classify the sample against the held button and the joystick state.
   always_comb begin
      desc      = '0;
      mode_in   = mode_ff;
      active_in = active_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      if (s2_vld_ff) begin
         if (mode_ff == MODE_NONE) begin
            if (s2_on_ff) begin
               desc.prs_vld = 1'b1;
               desc.prs_btn = s2_btn_ff;
               mode_in      = s2_btn_ff + 3'd1;
            end
         end else if (!(s2_on_ff && (s2_btn_ff == held_btn))) begin
            desc.rel_vld = 1'b1;
            desc.rel_btn = held_btn;
            mode_in      = MODE_NONE;
            // A button checked after the released one may still be pressed.
            if (s2_on_ff && (s2_btn_ff > held_btn)) begin
               desc.prs_vld = 1'b1;
               desc.prs_btn = s2_btn_ff;
               mode_in      = s2_btn_ff + 3'd1;
            end
         end
         if (in_circle) begin
            active_in = 1'b1;
            if ((last_x_ff != s2_x_ff) || (last_y_ff != s2_y_ff)) begin
               desc.stk_vld     = 1'b1;
               desc.stk_touched = 1'b1;
               desc.stk_x       = s2_x_ff;
               desc.stk_y       = s2_y_ff;
            end
            last_x_in = s2_x_ff;
            last_y_in = s2_y_ff;
         end else if (active_ff) begin
            active_in    = 1'b0;
            desc.stk_vld = 1'b1;
         end
      end
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NONE;
         active_ff <= 1'b0;
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         active_ff <= active_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
      end
   end

   assign push.vld  = s2_vld_ff;
   assign push.desc = desc;

endmodule

`default_nettype wire

[sv/tzbj_queue.sv]
// Small descriptor queue that decouples the classifier from the sequencer.
// Depends on tzbj_pkg; the writer guarantees it never pushes into a full queue.
`default_nettype none

module tzbj_queue import tzbj_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tzbj_entry_type    push,
   input  logic              pop,
   output tzbj_entry_type    head,
   output logic [QCNT_W-1:0] count
);

   tzbj_desc_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   // Storage write.
   always_ff @(posedge clock) begin
      if (push.vld) begin
         mem_ff[wr_ptr_ff] <= push.desc;
      end
   end

   assign count_in = count_ff + QCNT_W'(push.vld) - QCNT_W'(pop);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.vld) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign head.vld  = count_ff != '0;
   assign head.desc = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

[sv/tzbj_back.sv]
// Back end: walks the head descriptor's events; one word per ready cycle.
// Depends on tzbj_pkg and tzbj_rsp_if; reads from tzbj_queue.
`default_nettype none

module tzbj_back import tzbj_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tzbj_entry_type head,
   output logic           pop,
   tzbj_rsp_if.source     rsp_chan
);

   // Events of the head already sent: release, press, joystick.
   logic [2:0]         done_ff;
   logic [2:0]         done_in;
   logic               rsp_vld_ff;
   logic               rsp_vld_in;
   logic               kind_ff;
   logic [BEV_W-1:0]   bev_ff;
   logic [COORD_W-1:0] sx_ff;
   logic [COORD_W-1:0] sy_ff;
   logic               touched_ff;
   logic               last_ff;

   logic [2:0]         pending;
   logic [2:0]         sel;
   logic               out_free;
   logic               emit;
   logic               is_last;

   assign pending  = head.vld ? ({head.desc.stk_vld, head.desc.prs_vld,
                                  head.desc.rel_vld} & ~done_ff) : 3'b000;
   assign sel      = pending & (~pending + 3'd1);
   assign is_last  = (pending & (pending - 3'd1)) == 3'b000;
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign emit     = (pending != 3'b000) && out_free;

   // A descriptor without events is dropped at once.
   assign pop = head.vld && ((pending == 3'b000) || (out_free && is_last));

   always_comb begin
      done_in = done_ff;
      if (pop) begin
         done_in = 3'b000;
      end else if (emit) begin
         done_in = done_ff | sel;
      end
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      if (emit) begin
         rsp_vld_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff    <= 3'b000;
         rsp_vld_ff <= 1'b0;
      end else begin
         done_ff    <= done_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Output word, loaded with the earliest event still pending.
   always_ff @(posedge clock) begin
      if (emit) begin
         last_ff <= is_last;
         priority if (sel[0]) begin
            kind_ff    <= KIND_BUTTON;
            bev_ff     <= {head.desc.rel_btn, 1'b1};
            sx_ff      <= '0;
            sy_ff      <= '0;
            touched_ff <= 1'b0;
         end else if (sel[1]) begin
            kind_ff    <= KIND_BUTTON;
            bev_ff     <= {head.desc.prs_btn, 1'b0};
            sx_ff      <= '0;
            sy_ff      <= '0;
            touched_ff <= 1'b0;
         end else begin
            kind_ff    <= KIND_STICK;
            bev_ff     <= '0;
            sx_ff      <= head.desc.stk_x;
            sy_ff      <= head.desc.stk_y;
            touched_ff <= head.desc.stk_touched;
         end
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.event_kind    = kind_ff;
   assign rsp_chan.button_event  = bev_ff;
   assign rsp_chan.stick_x       = sx_ff;
   assign rsp_chan.stick_y       = sy_ff;
   assign rsp_chan.stick_touched = touched_ff;
   assign rsp_chan.last_of_run   = last_ff;

endmodule

`default_nettype wire
